### rtl/fbeq_pkg.sv
// Shared constants, types and state codes for the four-band biquad equalizer.
`timescale 1ns / 1ps
package fbeq_pkg;

  // Default structural parameters
  localparam int NUM_STAGES     = 4;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 26;

  // Fixed field and word widths
  localparam int GAIN_FRAC_BITS = 22;
  localparam int OPCODE_W       = 2;
  localparam int COEF_INDEX_W   = 5;
  localparam int COEF_W         = 32;
  localparam int HIST_W         = 32;
  localparam int GAIN_W         = 24;
  localparam int BYPASS_W       = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int PROD_W         = 64;
  // five 64-bit products plus the rounding constant
  localparam int ACC_W          = 67;

  localparam int TAPS           = 5;
  localparam int HIST_PER_STAGE = 4;

  localparam logic [BYPASS_W-1:0] BYPASS_RESET = 4'hF;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd4194304;

  localparam logic signed [HIST_W-1:0] HIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [HIST_W-1:0] HIST_MIN = 32'sh8000_0000;

  // Item opcodes
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_COEF   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_ROUND,
    ST_GAIN,
    ST_OUT
  } fbeq_state_t;

  typedef enum logic [1:0] {
    HSEL_ZERO,
    HSEL_HOLD,
    HSEL_X,
    HSEL_Y
  } fbeq_hsel_t;

  typedef struct packed {
    logic       load_x;
    logic       acc_init;
    logic       mul_en;
    logic       mul_x;
    logic       mul_gain;
    logic       acc_en;
    logic       acc_sub;
    logic       hold_en;
    logic       y_update;
    logic       out_load;
    fbeq_hsel_t hist_sel;
  } fbeq_dp_ctrl_t;

endpackage

### rtl/fbeq_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface fbeq_in_if #(
  parameter int SAMPLE_BITS = fbeq_pkg::SAMPLE_BITS
);
  logic                                    valid;
  logic                                    ready;
  logic [fbeq_pkg::OPCODE_W-1:0]           opcode;
  logic signed [SAMPLE_BITS-1:0]           sample_in;
  logic [fbeq_pkg::COEF_INDEX_W-1:0]       coef_index;
  logic signed [fbeq_pkg::COEF_W-1:0]      coef_value;

  modport source (output valid, opcode, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, opcode, sample_in, coef_index, coef_value, output ready);
endinterface

interface fbeq_out_if #(
  parameter int SAMPLE_BITS = fbeq_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

interface fbeq_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [fbeq_pkg::CFG_INDEX_W-1:0]   index;
  logic [fbeq_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fbeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fbeq_mac.sv
// Shared multiply-accumulate datapath: stage value, rounding, saturation and output gain.
`timescale 1ns / 1ps
module fbeq_mac #(
  parameter int SAMPLE_BITS    = fbeq_pkg::SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = fbeq_pkg::COEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  fbeq_pkg::fbeq_dp_ctrl_t               ctl,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic [fbeq_pkg::GAIN_W-1:0]           gain,
  input  logic signed [fbeq_pkg::COEF_W-1:0]    coef_rdata,
  input  logic signed [fbeq_pkg::HIST_W-1:0]    hist_rdata,
  output logic signed [fbeq_pkg::HIST_W-1:0]    hist_wdata,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic                                  clipped
);

  localparam int HW  = fbeq_pkg::HIST_W;
  localparam int PW  = fbeq_pkg::PROD_W;
  localparam int AW  = fbeq_pkg::ACC_W;
  localparam int YQW = AW - COEF_FRAC_BITS;
  localparam int GF  = fbeq_pkg::GAIN_FRAC_BITS;
  localparam int RQW = PW - GF;

  logic signed [HW-1:0]  x;
  logic signed [HW-1:0]  hold;
  logic                  clip;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  acc;

  logic signed [HW-1:0]  a_op;
  logic signed [HW-1:0]  b_op;

  logic signed [YQW-1:0] yq;
  logic                  y_ovf;
  logic signed [HW-1:0]  y_sat;

  logic signed [PW-1:0]  rsum;
  logic signed [RQW-1:0] rq;
  logic                  r_ovf;
  logic signed [SAMPLE_BITS-1:0] r_sat;

  always_comb begin
    a_op = (ctl.mul_x || ctl.mul_gain) ? x : hist_rdata;
    b_op = ctl.mul_gain ? signed'(HW'(gain)) : coef_rdata;
  end

  // Stage result: floor shift of the rounded sum, clamp to the history word
  always_comb begin
    yq    = acc[AW-1:COEF_FRAC_BITS];
    y_ovf = !((&yq[YQW-1:HW-1]) || (~|yq[YQW-1:HW-1]));
    if (y_ovf) begin
      y_sat = yq[YQW-1] ? fbeq_pkg::HIST_MIN : fbeq_pkg::HIST_MAX;
    end else begin
      y_sat = yq[HW-1:0];
    end
  end

  // Output: round half up after the gain product, clamp to the sample width
  always_comb begin
    rsum  = prod + (PW'(1) <<< (GF - 1));
    rq    = rsum[PW-1:GF];
    r_ovf = !((&rq[RQW-1:SAMPLE_BITS-1]) || (~|rq[RQW-1:SAMPLE_BITS-1]));
    if (r_ovf) begin
      r_sat = rq[RQW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      r_sat = rq[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    unique case (ctl.hist_sel)
      fbeq_pkg::HSEL_ZERO: hist_wdata = '0;
      fbeq_pkg::HSEL_HOLD: hist_wdata = hold;
      fbeq_pkg::HSEL_X:    hist_wdata = x;
      fbeq_pkg::HSEL_Y:    hist_wdata = y_sat;
      default:             hist_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_x) begin
      x    <= HW'(sample_in);
      clip <= 1'b0;
    end else if (ctl.y_update) begin
      x    <= y_sat;
      clip <= clip | y_ovf;
    end
    if (ctl.mul_en) begin
      prod <= a_op * b_op;
    end
    if (ctl.acc_init) begin
      acc <= AW'(1) <<< (COEF_FRAC_BITS - 1);
    end else if (ctl.acc_en) begin
      // feedback taps enter with a minus sign
      acc <= ctl.acc_sub ? acc - AW'(prod) : acc + AW'(prod);
    end
    if (ctl.hold_en) begin
      hold <= hist_rdata;
    end
    if (ctl.out_load) begin
      sample_out <= r_sat;
      clipped    <= clip | r_ovf;
    end
  end

endmodule

### rtl/fbeq_ctrl.sv
// Sequencer: item intake, memory addressing, clearing sweep and MAC schedule.
`timescale 1ns / 1ps
module fbeq_ctrl #(
  parameter int NUM_STAGES = fbeq_pkg::NUM_STAGES,
  localparam int CDEPTH    = NUM_STAGES * fbeq_pkg::TAPS,
  localparam int HDEPTH    = NUM_STAGES * fbeq_pkg::HIST_PER_STAGE,
  localparam int CA_W      = $clog2(CDEPTH),
  localparam int HA_W      = $clog2(HDEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fbeq_pkg::OPCODE_W-1:0]       opcode,
  input  logic [fbeq_pkg::COEF_INDEX_W-1:0]   coef_index,
  input  logic signed [fbeq_pkg::COEF_W-1:0]  coef_value,
  input  logic [fbeq_pkg::BYPASS_W-1:0]       bypass_mask,
  input  logic                                out_ready,
  output logic                                out_valid,
  output fbeq_pkg::fbeq_dp_ctrl_t             ctl,
  output logic                                coef_we,
  output logic [CA_W-1:0]                     coef_waddr,
  output logic [fbeq_pkg::COEF_W-1:0]         coef_wdata,
  output logic [CA_W-1:0]                     coef_raddr,
  output logic                                hist_we,
  output logic [HA_W-1:0]                     hist_waddr,
  output logic [HA_W-1:0]                     hist_raddr
);

  localparam int PW = $clog2(NUM_STAGES + 1);
  localparam int SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  fbeq_pkg::fbeq_state_t state, state_next;

  logic [PW-1:0]   pos;
  logic [2:0]      step;
  logic [CA_W-1:0] clr_cnt;

  logic            accept;
  logic            out_free;
  logic            bypassed;
  logic            pos_done;
  logic [1:0]      pos_lo;
  logic [SW-1:0]   stage;
  logic [CA_W-1:0] base_c;
  logic [HA_W-1:0] base_h;
  logic [2:0]      ctap;
  logic [2:0]      htap;

  assign in_ready = (state == fbeq_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pos_lo   = 2'(pos);
  assign bypassed = (32'(pos) < fbeq_pkg::BYPASS_W) && bypass_mask[pos_lo];
  assign pos_done = (pos == PW'(NUM_STAGES));

  // Processing order: first store stage, last store stage, then the middle ones
  always_comb begin
    if (pos == '0) begin
      stage = '0;
    end else if (pos == PW'(1)) begin
      stage = SW'(NUM_STAGES - 1);
    end else begin
      stage = SW'(pos - PW'(1));
    end
    base_c = CA_W'(CA_W'(stage) * CA_W'(fbeq_pkg::TAPS));
    base_h = HA_W'(HA_W'(stage) * HA_W'(fbeq_pkg::HIST_PER_STAGE));
    ctap   = (step < 3'd5) ? step : 3'd0;
    htap   = (step >= 3'd1 && step <= 3'd4) ? step - 3'd1 : 3'd0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fbeq_pkg::ST_CLEAR: begin
        if (clr_cnt == CA_W'(CDEPTH - 1)) state_next = fbeq_pkg::ST_IDLE;
      end
      fbeq_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == fbeq_pkg::OP_SAMPLE) begin
            state_next = fbeq_pkg::ST_CHECK;
          end else if (opcode == fbeq_pkg::OP_CLEAR) begin
            state_next = fbeq_pkg::ST_CLEAR;
          end
        end
      end
      fbeq_pkg::ST_CHECK: begin
        if (pos_done) begin
          state_next = fbeq_pkg::ST_GAIN;
        end else if (!bypassed) begin
          state_next = fbeq_pkg::ST_MAC;
        end
      end
      fbeq_pkg::ST_MAC: begin
        if (step == 3'd6) state_next = fbeq_pkg::ST_ROUND;
      end
      fbeq_pkg::ST_ROUND: state_next = fbeq_pkg::ST_CHECK;
      fbeq_pkg::ST_GAIN:  state_next = fbeq_pkg::ST_OUT;
      fbeq_pkg::ST_OUT: begin
        if (out_free) state_next = fbeq_pkg::ST_IDLE;
      end
      default: state_next = fbeq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.hist_sel = fbeq_pkg::HSEL_ZERO;
    coef_we    = 1'b0;
    coef_waddr = clr_cnt;
    coef_wdata = '0;
    coef_raddr = base_c + CA_W'(ctap);
    hist_we    = 1'b0;
    hist_waddr = base_h;
    hist_raddr = base_h + HA_W'(htap);
    unique case (state)
      fbeq_pkg::ST_CLEAR: begin
        coef_we = 1'b1;
        if (clr_cnt < CA_W'(HDEPTH)) begin
          hist_we    = 1'b1;
          hist_waddr = HA_W'(clr_cnt);
        end
      end
      fbeq_pkg::ST_IDLE: begin
        ctl.load_x = accept && (opcode == fbeq_pkg::OP_SAMPLE);
        // drop writes beyond the store
        if (accept && opcode == fbeq_pkg::OP_COEF && 32'(coef_index) < CDEPTH) begin
          coef_we    = 1'b1;
          coef_waddr = CA_W'(coef_index);
          coef_wdata = coef_value;
        end
      end
      fbeq_pkg::ST_MAC: begin
        ctl.acc_init = (step == 3'd0);
        ctl.mul_en   = (step >= 3'd1) && (step <= 3'd5);
        ctl.mul_x    = (step == 3'd1);
        ctl.acc_en   = (step >= 3'd2);
        ctl.acc_sub  = (step >= 3'd5);
        ctl.hold_en  = (step == 3'd2) || (step == 3'd4);
        // shift history once each old word has been read
        if (step == 3'd3) begin
          hist_we      = 1'b1;
          hist_waddr   = base_h + HA_W'(1);
          ctl.hist_sel = fbeq_pkg::HSEL_HOLD;
        end else if (step == 3'd5) begin
          hist_we      = 1'b1;
          hist_waddr   = base_h + HA_W'(3);
          ctl.hist_sel = fbeq_pkg::HSEL_HOLD;
        end else if (step == 3'd6) begin
          hist_we      = 1'b1;
          hist_waddr   = base_h;
          ctl.hist_sel = fbeq_pkg::HSEL_X;
        end
      end
      fbeq_pkg::ST_ROUND: begin
        ctl.y_update = 1'b1;
        hist_we      = 1'b1;
        hist_waddr   = base_h + HA_W'(2);
        ctl.hist_sel = fbeq_pkg::HSEL_Y;
      end
      fbeq_pkg::ST_GAIN: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_gain = 1'b1;
      end
      fbeq_pkg::ST_OUT: begin
        ctl.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbeq_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      pos       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fbeq_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CA_W'(1);
      end else begin
        clr_cnt <= '0;
      end
      if (state == fbeq_pkg::ST_IDLE) begin
        pos <= '0;
      end else if ((state == fbeq_pkg::ST_CHECK && !pos_done && bypassed) ||
                   state == fbeq_pkg::ST_ROUND) begin
        pos <= pos + PW'(1);
      end
      if (state == fbeq_pkg::ST_MAC) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/four_band_biquad_eq_cascade.sv
// Top level of the four-band cascaded biquad equalizer.
//
// Mono fixed-point equalizer: each sample item runs through the stages of
// NUM_STAGES direct-form-1 biquads (low shelf, high shelf, peaks) that are
// not bypassed, and a master gain. Coefficients and filter history live in
// two synchronous RAMs; a single 32x32 multiplier with a 67-bit accumulator
// computes the five products of a stage in the MAC state, then the ROUND
// state rounds, saturates and writes the new output history word. The MAC
// schedule is set by the single read port of each RAM. A coefficient write
// or an ignored opcode leaves the block idle for the next item. After reset
// and after a clear item the block sweeps both RAMs to zero, during which no
// item is accepted; configuration writes are taken at any time. Results sit
// in an output register, so the next item is accepted while a result waits.
`timescale 1ns / 1ps
module four_band_biquad_eq_cascade #(
  parameter int NUM_STAGES     = fbeq_pkg::NUM_STAGES,
  parameter int SAMPLE_BITS    = fbeq_pkg::SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = fbeq_pkg::COEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  fbeq_in_if.sink      items,
  fbeq_out_if.source   results,
  fbeq_cfg_if.sink     cfg
);

  localparam int CDEPTH = NUM_STAGES * fbeq_pkg::TAPS;
  localparam int HDEPTH = NUM_STAGES * fbeq_pkg::HIST_PER_STAGE;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int HA_W   = $clog2(HDEPTH);

  logic [fbeq_pkg::BYPASS_W-1:0] bypass_mask;
  logic [fbeq_pkg::GAIN_W-1:0]   master_gain;

  fbeq_pkg::fbeq_dp_ctrl_t ctl;

  logic                              coef_we;
  logic [CA_W-1:0]                   coef_waddr;
  logic [fbeq_pkg::COEF_W-1:0]       coef_wdata;
  logic [CA_W-1:0]                   coef_raddr;
  logic [fbeq_pkg::COEF_W-1:0]       coef_rdata;
  logic                              hist_we;
  logic [HA_W-1:0]                   hist_waddr;
  logic [HA_W-1:0]                   hist_raddr;
  logic signed [fbeq_pkg::HIST_W-1:0] hist_wdata;
  logic [fbeq_pkg::HIST_W-1:0]       hist_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_mask <= fbeq_pkg::BYPASS_RESET;
      master_gain <= fbeq_pkg::GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fbeq_pkg::CFG_BYPASS: bypass_mask <= cfg.data[fbeq_pkg::BYPASS_W-1:0];
        fbeq_pkg::CFG_GAIN:   master_gain <= cfg.data[fbeq_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fbeq_ctrl #(
    .NUM_STAGES (NUM_STAGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .opcode      (items.opcode),
    .coef_index  (items.coef_index),
    .coef_value  (items.coef_value),
    .bypass_mask (bypass_mask),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .ctl         (ctl),
    .coef_we     (coef_we),
    .coef_waddr  (coef_waddr),
    .coef_wdata  (coef_wdata),
    .coef_raddr  (coef_raddr),
    .hist_we     (hist_we),
    .hist_waddr  (hist_waddr),
    .hist_raddr  (hist_raddr)
  );

  fbeq_ram #(
    .WIDTH (fbeq_pkg::COEF_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  fbeq_ram #(
    .WIDTH (fbeq_pkg::HIST_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  fbeq_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .ctl        (ctl),
    .sample_in  (items.sample_in),
    .gain       (master_gain),
    .coef_rdata (signed'(coef_rdata)),
    .hist_rdata (signed'(hist_rdata)),
    .hist_wdata (hist_wdata),
    .sample_out (results.sample_out),
    .clipped    (results.clipped)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for the four-band biquad equalizer: predictor, stimulus and checks.
`timescale 1ns / 1ps

typedef logic [fbeq_pkg::OPCODE_W-1:0]        opcode_t;
typedef logic signed [fbeq_pkg::SAMPLE_BITS-1:0] sample_t;
typedef logic [fbeq_pkg::COEF_INDEX_W-1:0]    cidx_t;
typedef logic signed [fbeq_pkg::COEF_W-1:0]   coef_t;
typedef logic [fbeq_pkg::BYPASS_W-1:0]        mask_t;
typedef logic [fbeq_pkg::GAIN_W-1:0]          gain_t;
typedef logic [fbeq_pkg::CFG_INDEX_W-1:0]     cfg_index_t;
typedef logic [fbeq_pkg::CFG_DATA_W-1:0]      cfg_data_t;

typedef struct {
  sample_t sample;
  logic    clipped;
} eq_sample_t;

// Predicts equalizer output per accepted item and checks results in order.
class eq_sample_checker;
  int         coef[fbeq_pkg::NUM_STAGES*fbeq_pkg::TAPS];
  int         hist[fbeq_pkg::NUM_STAGES*fbeq_pkg::HIST_PER_STAGE];
  bit [fbeq_pkg::BYPASS_W-1:0] bypass;
  bit [fbeq_pkg::GAIN_W-1:0]   gain;
  eq_sample_t expected_samples[$];
  int         errors;

  function new();
    errors = 0;
    clear_store();
    bypass = fbeq_pkg::BYPASS_RESET;
    gain   = fbeq_pkg::GAIN_RESET;
  endfunction

  function void clear_store();
    foreach (coef[i]) coef[i] = 0;
    foreach (hist[i]) hist[i] = 0;
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function void write_reg(cfg_index_t idx, cfg_data_t data);
    if (idx == fbeq_pkg::CFG_BYPASS) bypass = data[fbeq_pkg::BYPASS_W-1:0];
    else if (idx == fbeq_pkg::CFG_GAIN) gain = data[fbeq_pkg::GAIN_W-1:0];
  endfunction

  function longint clamp(longint v, int bits, inout bit clip);
    longint top, bottom;
    top    = (longint'(1) <<< (bits - 1)) - 1;
    bottom = -top - 1;
    if (v > top) begin
      clip = 1'b1;
      return top;
    end
    if (v < bottom) begin
      clip = 1'b1;
      return bottom;
    end
    return v;
  endfunction

  // One direct-form-1 section; the five products are split into integer and
  // fraction parts so the 64-bit sum cannot wrap.
  function longint run_biquad(int s, longint x, inout bit clip);
    longint p[fbeq_pkg::TAPS];
    longint whole, frac, y, frac_mask;
    int     c0, h0;
    c0 = s * fbeq_pkg::TAPS;
    h0 = s * fbeq_pkg::HIST_PER_STAGE;
    frac_mask = (longint'(1) <<< fbeq_pkg::COEF_FRAC_BITS) - 1;
    p[0] = x * longint'(coef[c0]);
    p[1] = longint'(hist[h0]) * longint'(coef[c0+1]);
    p[2] = longint'(hist[h0+1]) * longint'(coef[c0+2]);
    p[3] = -(longint'(hist[h0+2]) * longint'(coef[c0+3]));
    p[4] = -(longint'(hist[h0+3]) * longint'(coef[c0+4]));
    whole = 0;
    frac  = 0;
    for (int k = 0; k < fbeq_pkg::TAPS; k++) begin
      whole += p[k] >>> fbeq_pkg::COEF_FRAC_BITS;
      frac  += p[k] & frac_mask;
    end
    frac  += longint'(1) <<< (fbeq_pkg::COEF_FRAC_BITS - 1);
    whole += frac >>> fbeq_pkg::COEF_FRAC_BITS;
    y = clamp(whole, fbeq_pkg::HIST_W, clip);
    hist[h0+1] = hist[h0];
    hist[h0+3] = hist[h0+2];
    hist[h0]   = int'(x);
    hist[h0+2] = int'(y);
    return y;
  endfunction

  function void note_item(opcode_t op, sample_t smp, cidx_t cidx, coef_t cval);
    eq_sample_t res;
    longint     x, g, r;
    bit         clip;
    int         s;
    if (op == fbeq_pkg::OP_COEF) begin
      if (cidx < fbeq_pkg::NUM_STAGES * fbeq_pkg::TAPS) coef[cidx] = cval;
    end else if (op == fbeq_pkg::OP_CLEAR) begin
      clear_store();
    end else if (op == fbeq_pkg::OP_SAMPLE) begin
      clip = 1'b0;
      x = smp;
      // processing order: low shelf, high shelf, then the peaks
      for (int pos = 0; pos < fbeq_pkg::NUM_STAGES; pos++) begin
        if (pos == 0) s = 0;
        else if (pos == 1) s = fbeq_pkg::NUM_STAGES - 1;
        else s = pos - 1;
        if (pos < fbeq_pkg::BYPASS_W && bypass[pos]) continue;
        x = run_biquad(s, x, clip);
      end
      g = gain;
      r = (x * g + (longint'(1) <<< (fbeq_pkg::GAIN_FRAC_BITS - 1)))
          >>> fbeq_pkg::GAIN_FRAC_BITS;
      r = clamp(r, fbeq_pkg::SAMPLE_BITS, clip);
      res.sample  = r[fbeq_pkg::SAMPLE_BITS-1:0];
      res.clipped = clip;
      expected_samples.push_back(res);
    end
  endfunction

  task check_result(sample_t got_sample, logic got_clip);
    eq_sample_t want;
    if (expected_samples.size() == 0) begin
      report($sformatf("unexpected result: sample %0d clipped %0b", got_sample, got_clip));
      return;
    end
    want = expected_samples.pop_front();
    if (got_sample !== want.sample)
      report($sformatf("sample_out %0d, want %0d", got_sample, want.sample));
    if (got_clip !== want.clipped)
      report($sformatf("clipped %0b, want %0b", got_clip, want.clipped));
  endtask
endclass

module testbench;
  localparam opcode_t OP_UNUSED = 2'd3;
  localparam int TAP_B0 = 0;
  localparam int TAP_B1 = 1;
  localparam int TAP_B2 = 2;
  localparam int TAP_A1 = 3;
  localparam int TAP_A2 = 4;
  localparam int BAND_LOW_SHELF  = 0;
  localparam int BAND_PEAK1      = 1;
  localparam int BAND_PEAK2      = 2;
  localparam int BAND_HIGH_SHELF = 3;
  localparam sample_t SAMPLE_MAX = {1'b0, {(fbeq_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(fbeq_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN  = 32'sh8000_0000;
  localparam coef_t COEF_UNIT = 32'sd1 <<< fbeq_pkg::COEF_FRAC_BITS;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_CYCLES     = 300;

  logic clk = 1'b0;
  logic rst;
  bit   tx_steady   = 1'b0;
  bit   rx_steady   = 1'b0;
  bit   rx_hold_req = 1'b0;

  eq_sample_checker sb = new();

  fbeq_in_if  items_ch ();
  fbeq_out_if results_ch ();
  fbeq_cfg_if cfg_ch ();

  four_band_biquad_eq_cascade dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  always #5 clk = ~clk;

  // Offer one item after a random gap (none in steady mode); valid stays high across back-to-back items.
  task send_item(opcode_t op, sample_t smp, cidx_t cidx, coef_t cval);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.opcode     <= op;
    items_ch.sample_in  <= smp;
    items_ch.coef_index <= cidx;
    items_ch.coef_value <= cval;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_item(op, smp, cidx, cval);
  endtask

  task send_sample(sample_t smp);
    send_item(fbeq_pkg::OP_SAMPLE, smp, cidx_t'($urandom), coef_t'($urandom));
  endtask

  task write_coef(int stage, int tap, coef_t cval);
    send_item(fbeq_pkg::OP_COEF, sample_t'($urandom),
              cidx_t'(stage * fbeq_pkg::TAPS + tap), cval);
  endtask

  // Load a full stage; tame sets keep the poles inside the unit circle.
  task program_stage(int stage, bit wild);
    int a1, a2, bound;
    int c[fbeq_pkg::TAPS];
    a2 = int'($urandom_range(0, 107374182)) - 53687091;
    bound = (((1 << fbeq_pkg::COEF_FRAC_BITS) + a2) / 10) * 9;
    a1 = int'($urandom_range(0, 2 * bound)) - bound;
    for (int k = TAP_B0; k <= TAP_B2; k++)
      c[k] = int'($urandom_range(0, 1 << 28)) - (1 << 27);
    c[TAP_A1] = a1;
    c[TAP_A2] = a2;
    if (wild) foreach (c[k]) c[k] = $urandom;
    for (int k = 0; k < fbeq_pkg::TAPS; k++) write_coef(stage, k, c[k]);
  endtask

  task release_input();
    items_ch.valid <= 1'b0;
  endtask

  task cfg_write(cfg_index_t idx, cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all results, then let a pending write or clear sweep finish.
  task wait_until_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_band_config(mask_t mask, gain_t gval);
    cfg_data_t word;
    word = cfg_data_t'($urandom);
    word[fbeq_pkg::BYPASS_W-1:0] = mask;
    cfg_write(fbeq_pkg::CFG_BYPASS, word);
    cfg_write(fbeq_pkg::CFG_GAIN, gval);
  endtask

  initial begin : result_sink
    int stall;
    results_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (rx_hold_req) begin
        stall = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        results_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!results_ch.valid);
      sb.check_result(results_ch.sample_out, results_ch.clipped);
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick, counted, w;
    cidx_t   cidx;
    mask_t   mask;
    gain_t   gval;
    sample_t smp;

    rst = 1'b1;
    items_ch.valid      <= 1'b0;
    items_ch.opcode     <= fbeq_pkg::OP_SAMPLE;
    items_ch.sample_in  <= '0;
    items_ch.coef_index <= '0;
    items_ch.coef_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= fbeq_pkg::CFG_BYPASS;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every stage bypassed at unity gain
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    send_item(OP_UNUSED, sample_t'($urandom), cidx_t'($urandom), coef_t'($urandom));
    send_item(fbeq_pkg::OP_COEF, sample_t'($urandom), 5'd25, COEF_MAX);
    release_input();
    wait_until_idle();

    // low shelf alone at full gain with extreme taps: stage and output clipping
    set_band_config(4'b1110, '1);
    write_coef(BAND_LOW_SHELF, TAP_B0, COEF_MAX);
    write_coef(BAND_LOW_SHELF, TAP_B1, COEF_MIN);
    write_coef(BAND_LOW_SHELF, TAP_B2, COEF_MAX);
    write_coef(BAND_LOW_SHELF, TAP_A1, COEF_MIN);
    write_coef(BAND_LOW_SHELF, TAP_A2, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_item(fbeq_pkg::OP_CLEAR, sample_t'($urandom), cidx_t'($urandom), coef_t'($urandom));
    send_sample(SAMPLE_MIN);
    write_coef(BAND_HIGH_SHELF, TAP_B0, COEF_UNIT);
    release_input();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_until_idle();
      case (ph)
        0: begin mask = '0;               gval = fbeq_pkg::GAIN_RESET; end
        1: begin mask = '1;               gval = '1; end
        2: begin mask = mask_t'($urandom); gval = '0; end
        4: begin
          mask = '0;
          gval = gain_t'($urandom_range(0, fbeq_pkg::GAIN_RESET));
        end
        default: begin mask = mask_t'($urandom); gval = gain_t'($urandom); end
      endcase
      set_band_config(mask, gval);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 3 == 2);
      if (ph == 2) rx_hold_req = 1'b1;

      program_stage(BAND_LOW_SHELF, 1'b0);
      program_stage(BAND_PEAK1, 1'b0);
      program_stage(BAND_PEAK2, 1'b0);
      program_stage(BAND_HIGH_SHELF, 1'b0);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          program_stage($urandom_range(0, fbeq_pkg::NUM_STAGES - 1),
                        $urandom_range(0, 9) == 0);
          counted += fbeq_pkg::TAPS;
        end else if (pick < 8) begin
          send_item(OP_UNUSED, sample_t'($urandom), cidx_t'($urandom), coef_t'($urandom));
        end else if (pick < 11) begin
          // any index, any word: out-of-range indexes must be dropped
          cidx = cidx_t'($urandom);
          send_item(fbeq_pkg::OP_COEF, sample_t'($urandom), cidx, coef_t'($urandom));
          if (cidx < fbeq_pkg::NUM_STAGES * fbeq_pkg::TAPS) counted++;
        end else if (pick < 12) begin
          send_item(fbeq_pkg::OP_CLEAR, sample_t'($urandom), cidx_t'($urandom),
                    coef_t'($urandom));
          counted++;
        end else begin
          case ($urandom_range(0, 9))
            0:       smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3, 4, 5: smp = sample_t'($urandom);
            default: smp = sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
          endcase
          send_sample(smp);
          counted++;
        end
      end
      release_input();
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    for (w = 0; w < 2000 && sb.pending() != 0; w++) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/fbeq_pkg.sv
rtl/fbeq_if.sv
rtl/fbeq_ram.sv
rtl/fbeq_mac.sv
rtl/fbeq_ctrl.sv
rtl/four_band_biquad_eq_cascade.sv
sim/testbench.sv
